// ===== sv/bgq_pkg.sv =====
package bgq_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W = 32;
  localparam int REG_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd5;

  localparam logic [REG_W-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [REG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [REG_W-1:0] REPEAT_RST       = 16'd300;
  localparam logic [REG_W-1:0] CLICK_RST        = 16'd300;
  localparam logic [REG_W-1:0] DOUBLE_CLICK_RST = 16'd400;
  localparam logic [REG_W-1:0] IDLE_TIMEOUT_RST = 16'd10000;

  typedef struct packed {
    logic [NOW_W-1:0] now;
    logic             pressed;
  } in_item_t;

  typedef struct packed {
    logic key_down;
    logic key_up;
    logic was_long;
    logic auto_repeat;
    logic long_press;
    logic click;
    logic double_click;
    logic inactive;
  } out_item_t;

endpackage

// ===== sv/button_gesture_qualifier_core.sv =====
// Button gesture qualifier.
// Input channel: in_valid, in_stall, in_data carries the current time and the
// raw button level. One result item is produced for every accepted input item.
// Result channel: out_valid, out_stall, out_data carries the event flags
// (key_down, key_up, was_long, auto_repeat, long_press, click, double_click,
// inactive), all zero when nothing fires.
// out_valid rises in the cycle after acceptance. One item is accepted per
// cycle while the receiver does not stall; the state update and all event
// logic sit between acceptance and the output register.
// When the receiver stalls, the output register holds its item and in_stall
// rises, so at most one finished item waits and none is lost.
// Configuration writes take effect at the edge where cfg_we is high; indexes
// beyond the register list are ignored. They are meant to happen while idle.
// A synchronous active-low reset clears all gesture state, drops out_valid and
// reloads the default register values.
module button_gesture_qualifier_core #(
  parameter int TIME_BITS = bgq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bgq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bgq_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bgq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgq_pkg::REG_W-1:0]      cfg_data
);

  typedef logic [TIME_BITS-1:0] tick_t;

  logic [bgq_pkg::REG_W-1:0] debounce_delay_r, long_press_delay_r, repeat_delay_r;
  logic [bgq_pkg::REG_W-1:0] click_time_r, double_click_time_r, idle_timeout_r;

  logic  last_level_r, last_level_nxt;
  tick_t bounce_deadline_r, bounce_deadline_nxt;
  tick_t long_deadline_r, long_deadline_nxt;
  tick_t repeat_deadline_r, repeat_deadline_nxt;
  tick_t click_deadline_r, click_deadline_nxt;
  tick_t double_deadline_r, double_deadline_nxt;
  tick_t last_activity_r, last_activity_nxt;

  logic               out_valid_r;
  bgq_pkg::out_item_t out_data_r, out_data_nxt;

  logic  in_accept;
  tick_t now_t;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign now_t     = TIME_BITS'(in_data.now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_delay_r    <= bgq_pkg::DEBOUNCE_RST;
      long_press_delay_r  <= bgq_pkg::LONG_PRESS_RST;
      repeat_delay_r      <= bgq_pkg::REPEAT_RST;
      click_time_r        <= bgq_pkg::CLICK_RST;
      double_click_time_r <= bgq_pkg::DOUBLE_CLICK_RST;
      idle_timeout_r      <= bgq_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgq_pkg::CFG_DEBOUNCE:     debounce_delay_r    <= cfg_data;
        bgq_pkg::CFG_LONG_PRESS:   long_press_delay_r  <= cfg_data;
        bgq_pkg::CFG_REPEAT:       repeat_delay_r      <= cfg_data;
        bgq_pkg::CFG_CLICK:        click_time_r        <= cfg_data;
        bgq_pkg::CFG_DOUBLE_CLICK: double_click_time_r <= cfg_data;
        bgq_pkg::CFG_IDLE_TIMEOUT: idle_timeout_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_level_nxt      = last_level_r;
    bounce_deadline_nxt = bounce_deadline_r;
    long_deadline_nxt   = long_deadline_r;
    repeat_deadline_nxt = repeat_deadline_r;
    click_deadline_nxt  = click_deadline_r;
    double_deadline_nxt = double_deadline_r;
    last_activity_nxt   = last_activity_r;
    out_data_nxt        = '0;

    if (now_t >= bounce_deadline_r) begin
      if (in_data.pressed == last_level_r) begin
        if (!in_data.pressed) begin
          if ((now_t - last_activity_r) >= TIME_BITS'(idle_timeout_r)) begin
            out_data_nxt.inactive = 1'b1;
            last_activity_nxt     = now_t;
          end
        end else begin
          if ((repeat_deadline_r != '0) && (now_t >= repeat_deadline_r)) begin
            repeat_deadline_nxt      = now_t + TIME_BITS'(repeat_delay_r);
            out_data_nxt.auto_repeat = 1'b1;
          end
          if ((long_deadline_r != '0) && (now_t >= long_deadline_r)) begin
            long_deadline_nxt       = '0;
            out_data_nxt.long_press = 1'b1;
          end
        end
      end else if (bounce_deadline_r == '0) begin
        bounce_deadline_nxt = now_t + TIME_BITS'(debounce_delay_r);
      end else begin
        bounce_deadline_nxt = '0;
        last_activity_nxt   = now_t;
        last_level_nxt      = in_data.pressed;
        if (in_data.pressed) begin
          long_deadline_nxt     = now_t + TIME_BITS'(long_press_delay_r);
          repeat_deadline_nxt   = now_t + TIME_BITS'(repeat_delay_r);
          click_deadline_nxt    = now_t + TIME_BITS'(click_time_r);
          out_data_nxt.key_down = 1'b1;
        end else begin
          out_data_nxt.key_up   = 1'b1;
          out_data_nxt.was_long = (long_deadline_r == '0);
          repeat_deadline_nxt   = '0;
          long_deadline_nxt     = '0;
          if (now_t < click_deadline_r) begin
            out_data_nxt.click = 1'b1;
            click_deadline_nxt = '0;
          end
          if (now_t < double_deadline_r) begin
            out_data_nxt.double_click = 1'b1;
          end else begin
            double_deadline_nxt = now_t + TIME_BITS'(double_click_time_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r      <= 1'b0;
      bounce_deadline_r <= '0;
      long_deadline_r   <= '0;
      repeat_deadline_r <= '0;
      click_deadline_r  <= '0;
      double_deadline_r <= '0;
      last_activity_r   <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_accept) begin
        last_level_r      <= last_level_nxt;
        bounce_deadline_r <= bounce_deadline_nxt;
        long_deadline_r   <= long_deadline_nxt;
        repeat_deadline_r <= repeat_deadline_nxt;
        click_deadline_r  <= click_deadline_nxt;
        double_deadline_r <= double_deadline_nxt;
        last_activity_r   <= last_activity_nxt;
        out_valid_r       <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
